>>> sv/i2c_master_byte_engine_defines.svh
// Assertion macros shared by the checker of the I2C master byte engine.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// Condition a in a cycle requires condition b in the same cycle.
`define ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("I2C master check failed: same-cycle implication");

// Condition a in a cycle requires condition b in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("I2C master check failed: next-cycle implication");

`endif

>>> sv/i2cm_pkg.sv
// Types, state codes and constants of the I2C master byte engine.
package i2cm_pkg;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'd0,
      ST_START_A   = 4'd1,
      ST_START_B   = 4'd2,
      ST_STOP_LOW  = 4'd3,
      ST_STOP_HIGH = 4'd4,
      ST_STOP_END  = 4'd5,
      ST_WR_LOW    = 4'd6,
      ST_WR_HIGH   = 4'd7,
      ST_ACK_SETUP = 4'd8,
      ST_ACK_POLL  = 4'd9,
      ST_RD_LOW    = 4'd10,
      ST_RD_HIGH   = 4'd11,
      ST_RA_LOW    = 4'd12,
      ST_RA_HIGH   = 4'd13
   } seq_state_type;

   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_ACK_TIMEOUT = 1'b1;

   localparam logic [7:0] PHASE_TICKS_RESET = 8'd2;
   localparam logic [9:0] ACK_TIMEOUT_RESET = 10'd250;
   localparam logic [7:0] PHASE_MAX         = 8'd255;
   localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } i2cm_req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_released;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_missing;
   } i2cm_rsp_type;

   typedef struct packed {
      seq_state_type seq;
      logic [3:0]    bit_count;
      logic [7:0]    shift;
      logic [7:0]    phase_count;
      logic [9:0]    poll_count;
      logic          ack_choice;
      logic          scl;
      logic          sda;
      logic          sda_rel;
      logic [7:0]    rx_hold;
      logic          miss;
   } i2cm_core_type;

   localparam i2cm_core_type CORE_RESET = '{
      seq:         ST_IDLE,
      bit_count:   4'd0,
      shift:       8'd0,
      phase_count: 8'd0,
      poll_count:  10'd0,
      ack_choice:  1'b0,
      scl:         1'b1,
      sda:         1'b1,
      sda_rel:     1'b0,
      rx_hold:     8'd0,
      miss:        1'b0
   };

endpackage

>>> sv/i2cm_step.sv
// One tick of the I2C bus sequencer: next sequencer state and the result of the tick.
module i2cm_step import i2cm_pkg::*; (
   input  i2cm_core_type cur,
   input  logic [7:0]    phase_ticks,
   input  logic [9:0]    ack_timeout,
   input  i2cm_req_type  req,
   output i2cm_core_type nxt,
   output i2cm_rsp_type  rsp
);

   logic [7:0]    plen;
   logic [7:0]    pc_inc;
   logic          expire;
   logic [3:0]    bc_inc;
   seq_state_type state_in;
   logic          enter;
   logic          done;
   i2cm_core_type mid;

   assign plen   = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
   assign pc_inc = (cur.phase_count != PHASE_MAX) ? cur.phase_count + 8'd1 : cur.phase_count;
   assign expire = (pc_inc >= plen);
   assign bc_inc = cur.bit_count + 4'd1;

   always_comb begin
      state_in = cur.seq;
      enter    = 1'b0;
      case (cur.seq)
         ST_IDLE: begin
            case (req.cmd)
               CMD_START: begin
                  state_in = ST_START_A;
                  enter    = 1'b1;
               end
               CMD_STOP: begin
                  state_in = ST_STOP_LOW;
                  enter    = 1'b1;
               end
               CMD_WRITE: begin
                  state_in = ST_WR_LOW;
                  enter    = 1'b1;
               end
               CMD_READ: begin
                  state_in = ST_RD_LOW;
                  enter    = 1'b1;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ACK_POLL: begin
            if (!req.sda_in) begin
               state_in = ST_IDLE;
            end else if (cur.poll_count >= ack_timeout) begin
               state_in = ST_STOP_LOW;
               enter    = 1'b1;
            end
         end
         ST_START_A, ST_START_B, ST_STOP_LOW, ST_STOP_HIGH, ST_STOP_END, ST_WR_LOW,
         ST_WR_HIGH, ST_ACK_SETUP, ST_RD_LOW, ST_RD_HIGH, ST_RA_LOW, ST_RA_HIGH: begin
            if (expire) begin
               enter = 1'b1;
               case (cur.seq)
                  ST_START_A:   state_in = ST_START_B;
                  ST_STOP_LOW:  state_in = ST_STOP_HIGH;
                  ST_STOP_HIGH: state_in = ST_STOP_END;
                  ST_WR_LOW:    state_in = ST_WR_HIGH;
                  ST_WR_HIGH:   state_in = (bc_inc >= BITS_PER_BYTE) ? ST_ACK_SETUP : ST_WR_LOW;
                  ST_ACK_SETUP: state_in = ST_ACK_POLL;
                  ST_RD_LOW:    state_in = ST_RD_HIGH;
                  ST_RD_HIGH:   state_in = (bc_inc >= BITS_PER_BYTE) ? ST_RA_LOW : ST_RD_LOW;
                  ST_RA_LOW:    state_in = ST_RA_HIGH;
                  default: begin
                     state_in = ST_IDLE;
                     enter    = 1'b0;
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mid  = cur;
      done = 1'b0;
      case (cur.seq)
         ST_IDLE: begin
            if (req.cmd == CMD_WRITE) begin
               mid.shift     = req.tx_byte;
               mid.bit_count = 4'd0;
               mid.miss      = 1'b0;
            end else if (req.cmd == CMD_READ) begin
               mid.ack_choice = req.send_ack;
               mid.shift      = 8'd0;
               mid.bit_count  = 4'd0;
            end
         end
         ST_ACK_POLL: begin
            if (!req.sda_in) begin
               mid.scl = 1'b0;
               done    = 1'b1;
            end else if (cur.poll_count >= ack_timeout) begin
               mid.miss = 1'b1;
            end else begin
               mid.poll_count = cur.poll_count + 10'd1;
            end
         end
         default: begin
            mid.phase_count = pc_inc;
            if (expire) begin
               case (cur.seq)
                  ST_START_B: begin
                     mid.scl = 1'b0;
                     done    = 1'b1;
                  end
                  ST_STOP_END: done = 1'b1;
                  ST_WR_HIGH: begin
                     mid.shift     = {cur.shift[6:0], 1'b0};
                     mid.bit_count = bc_inc;
                  end
                  ST_RD_HIGH: mid.bit_count = bc_inc;
                  ST_RA_HIGH: begin
                     mid.scl     = 1'b0;
                     mid.rx_hold = cur.shift;
                     done        = 1'b1;
                  end
                  default: mid.bit_count = mid.bit_count;
               endcase
            end
         end
      endcase

      nxt     = mid;
      nxt.seq = state_in;
      if (enter) begin
         nxt.phase_count = 8'd0;
         case (state_in)
            ST_START_A: begin
               nxt.scl     = 1'b1;
               nxt.sda     = 1'b1;
               nxt.sda_rel = 1'b0;
            end
            ST_START_B: begin
               nxt.scl     = 1'b1;
               nxt.sda     = 1'b0;
               nxt.sda_rel = 1'b0;
            end
            ST_STOP_LOW: begin
               nxt.scl     = 1'b0;
               nxt.sda     = 1'b0;
               nxt.sda_rel = 1'b0;
            end
            ST_STOP_HIGH: begin
               nxt.scl     = 1'b1;
               nxt.sda     = 1'b0;
               nxt.sda_rel = 1'b0;
            end
            ST_STOP_END: begin
               nxt.scl     = 1'b1;
               nxt.sda     = 1'b1;
               nxt.sda_rel = 1'b0;
            end
            ST_WR_LOW: begin
               nxt.scl     = 1'b0;
               nxt.sda     = mid.shift[7];
               nxt.sda_rel = 1'b0;
            end
            ST_ACK_SETUP: begin
               nxt.scl        = 1'b0;
               nxt.sda        = 1'b1;
               nxt.sda_rel    = 1'b1;
               nxt.poll_count = 10'd0;
            end
            ST_RD_LOW: begin
               nxt.scl     = 1'b0;
               nxt.sda     = 1'b1;
               nxt.sda_rel = 1'b1;
            end
            ST_RD_HIGH: begin
               nxt.scl   = 1'b1;
               nxt.shift = {mid.shift[6:0], req.sda_in};
            end
            ST_RA_LOW: begin
               nxt.scl     = 1'b0;
               nxt.sda     = ~mid.ack_choice;
               nxt.sda_rel = 1'b0;
            end
            ST_WR_HIGH, ST_ACK_POLL, ST_RA_HIGH: nxt.scl = 1'b1;
            default: nxt.seq = ST_IDLE;
         endcase
      end
   end

   always_comb begin
      rsp.scl_level    = nxt.scl;
      rsp.sda_level    = nxt.sda_rel | nxt.sda;
      rsp.sda_released = nxt.sda_rel;
      rsp.busy_res     = (nxt.seq != ST_IDLE);
      rsp.done_res     = done;
      rsp.rx_byte      = nxt.rx_hold;
      rsp.ack_missing  = nxt.miss;
   end

endmodule

>>> sv/i2c_master_byte_engine.sv
// The result of a tick transaction is registered in the result buffer and offered from its head.
// One tick per cycle while the result buffer has room; the sequencer state updates in a single registered pass.
// A two-entry result buffer lets ticks keep flowing while the result side stalls, until both entries fill.
// Reset (synchronous, active high) returns the sequencer to idle with SCL and SDA high,
// phase length 2 and ACK timeout 250, and empties the result buffer.
module i2c_master_byte_engine import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_tx_byte,
   input  logic       req_send_ack,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_sda_released,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_ack_missing,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [9:0] csr_wdata
);

   logic [7:0]    phase_ticks_ff;
   logic [9:0]    ack_timeout_ff;
   i2cm_core_type core_ff;
   i2cm_core_type core_in;
   i2cm_req_type  req;
   i2cm_rsp_type  step_rsp;
   i2cm_rsp_type  head_ff;
   i2cm_rsp_type  tail_ff;
   logic [1:0]    count_ff;
   logic [1:0]    count_in;
   logic          push;
   logic          pop;

   assign req.cmd      = req_cmd;
   assign req.tx_byte  = req_tx_byte;
   assign req.send_ack = req_send_ack;
   assign req.sda_in   = req_sda_in;

   i2cm_step u_step (
      .cur         (core_ff),
      .phase_ticks (phase_ticks_ff),
      .ack_timeout (ack_timeout_ff),
      .req         (req),
      .nxt         (core_in),
      .rsp         (step_rsp)
   );

   assign req_ready = !reset && (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign push      = req_valid & req_ready;
   assign pop       = rsp_valid & rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
         core_ff        <= CORE_RESET;
         count_ff       <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_PHASE_TICKS) begin
               phase_ticks_ff <= csr_wdata[7:0];
            end else begin
               ack_timeout_ff <= csr_wdata;
            end
         end
         if (push) begin
            core_ff <= core_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_ff <= step_rsp;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_ff <= step_rsp;
            end else if (push) begin
               tail_ff <= step_rsp;
            end
         end
         default: begin
            if (pop) begin
               head_ff <= tail_ff;
            end
         end
      endcase
   end

   assign rsp_scl_level    = head_ff.scl_level;
   assign rsp_sda_level    = head_ff.sda_level;
   assign rsp_sda_released = head_ff.sda_released;
   assign rsp_busy_res     = head_ff.busy_res;
   assign rsp_done_res     = head_ff.done_res;
   assign rsp_rx_byte      = head_ff.rx_byte;
   assign rsp_ack_missing  = head_ff.ack_missing;

endmodule

>>> sv/i2cm_checker.sv
// Port-level checker for the I2C master byte engine and its bind to the top level.
`include "i2c_master_byte_engine_defines.svh"

module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_sda_level,
   input logic       rsp_sda_released,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_rx_byte
);

   // A completing command is never reported as still in progress.
   `ASSERT_SAME(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)

   // A released SDA line always reads back high.
   `ASSERT_SAME(a_released_high, clock, reset, rsp_valid && rsp_sda_released, rsp_sda_level)

   // A result that is not taken stays offered with the same received byte.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rx_byte))

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);
